// ===== rtl/llis_pkg.sv =====
`default_nettype none

package llis_pkg;

   localparam int LINE_W = 16;
   localparam int CPU_OUT_W = 3;
   localparam int LOAD_W = 7;
   localparam int CFG_W = 4;
   localparam int IDX_CMP_W = 7;
   localparam logic [LOAD_W-1:0] LOAD_MAX = 7'd127;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_CPU = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic                 active;
      logic                 hit;
      logic [LINE_W-1:0]    key;
      logic [CPU_OUT_W-1:0] cpu;
   } entry_token_type;

   typedef struct packed {
      logic                 en;
      logic [LINE_W-1:0]    line;
      logic [CPU_OUT_W-1:0] cpu;
   } entry_write_type;

endpackage

`default_nettype wire

// ===== rtl/llis_entry_cell.sv =====
`default_nettype none

module llis_entry_cell
   import llis_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire entry_token_type  tok_in,
   output      entry_token_type  tok_out,
   input  wire entry_write_type  wr,
   input  wire logic [IDX_W-1:0] wr_index
);

   logic                 valid_ff, valid_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic [CPU_OUT_W-1:0] cpu_ff, cpu_in;
   entry_token_type      tok_ff, tok_in_next;
   logic                 write_here;
   logic                 match;

   always_comb begin
      write_here = wr.en && (wr_index == IDX_W'(INDEX));
      valid_in = valid_ff | write_here;
      line_in = write_here ? wr.line : line_ff;
      cpu_in = write_here ? wr.cpu : cpu_ff;

      match = valid_ff && (line_ff == tok_in.key);
      tok_in_next = tok_in;
      if (!tok_in.hit && match) begin
         tok_in_next.hit = 1'b1;
         tok_in_next.cpu = cpu_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff.active <= tok_in_next.active;
      end
      line_ff <= line_in;
      cpu_ff <= cpu_in;
      tok_ff.hit <= tok_in_next.hit;
      tok_ff.key <= tok_in_next.key;
      tok_ff.cpu <= tok_in_next.cpu;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// ===== rtl/llis_cpu_cell.sv =====
`default_nettype none

module llis_cpu_cell
   import llis_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CPU_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CFG_W-1:0]  cpus_in_use,
   input  wire logic              in_active,
   input  wire logic              in_found,
   input  wire logic [CPU_W-1:0]  in_best,
   input  wire logic [LOAD_W-1:0] in_count,
   output      logic              out_active,
   output      logic              out_found,
   output      logic [CPU_W-1:0]  out_best,
   output      logic [LOAD_W-1:0] out_count,
   input  wire logic              inc_en,
   input  wire logic [CPU_W-1:0]  inc_index
);

   logic [LOAD_W-1:0] count_ff, count_in;
   logic              active_ff;
   logic              found_ff, found_in;
   logic [CPU_W-1:0]  best_ff, best_in;
   logic [LOAD_W-1:0] bcount_ff, bcount_in;
   logic              participate;
   logic              take;

   always_comb begin
      participate = IDX_CMP_W'(INDEX) < {{(IDX_CMP_W-CFG_W){1'b0}}, cpus_in_use};
      take = in_active && participate && (!in_found || (count_ff < in_count));
      found_in = in_found | take;
      best_in = take ? CPU_W'(INDEX) : in_best;
      bcount_in = take ? count_ff : in_count;
      count_in = count_ff;
      if (inc_en && (inc_index == CPU_W'(INDEX)) && (count_ff < LOAD_MAX)) begin
         count_in = count_ff + LOAD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         active_ff <= in_active;
      end
      found_ff <= found_in;
      best_ff <= best_in;
      bcount_ff <= bcount_in;
   end

   assign out_active = active_ff;
   assign out_found = found_ff;
   assign out_best = best_ff;
   assign out_count = bcount_ff;

endmodule

`default_nettype wire

// ===== rtl/least_loaded_interrupt_steering.sv =====
`default_nettype none

// Steers interrupt lines to CPUs. A request carries a line number; the block
// looks it up in a table of assigned lines and returns the stored CPU, or else
// assigns the line to the least loaded CPU in use (ties to the lowest index),
// records it and returns that CPU; with no CPU in use or a full table it
// returns an error status instead. The table is a row of cells that the
// lookup key walks through one cell per cycle, while the load search walks a
// second row of per-CPU cells in parallel. busy is high from the edge that
// accepts a request until the result strobe rises, one request is handled at
// a time, and the next request can be accepted at the edge that takes the
// result. rsp_valid is high for exactly one cycle per request and cannot be
// held off by the receiver.
// The cpus_in_use register sits at byte address 0 and must only be written
// while busy is low.
module least_loaded_interrupt_steering
   import llis_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int MAX_CPUS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic [LINE_W-1:0]    req_line_number,
   output      logic                 rsp_valid,
   output      logic [1:0]           rsp_status,
   output      logic [CPU_OUT_W-1:0] rsp_target_cpu,
   output      logic [LINE_W-1:0]    rsp_vector_number,
   output      logic                 rsp_newly_assigned,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output      logic [31:0]          prdata,
   output      logic                 pready
);

   localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CPU_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  cpus_ff, cpus_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              tbl_done_ff, tbl_done_in;
   logic              hit_ff, hit_in;
   logic [CPU_OUT_W-1:0] hit_cpu_ff, hit_cpu_in;
   logic              cpu_done_ff, cpu_done_in;
   logic [CPU_W-1:0]  best_ff, best_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [CPU_OUT_W-1:0] rsp_cpu_ff, rsp_cpu_in;
   logic [LINE_W-1:0]    rsp_vec_ff, rsp_vec_in;
   logic                 rsp_new_ff, rsp_new_in;

   logic            accept;
   logic            cfg_write;
   entry_write_type wr;
   logic            inc_en;

   entry_token_type   etok [TABLE_ENTRIES+1];
   logic              c_active [MAX_CPUS+1];
   logic              c_found [MAX_CPUS+1];
   logic [CPU_W-1:0]  c_best [MAX_CPUS+1];
   logic [LOAD_W-1:0] c_count [MAX_CPUS+1];

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && !paddr[2];
   assign prdata = paddr[2] ? 32'd0 : {{(32-CFG_W){1'b0}}, cpus_ff};
   assign cpus_in = cfg_write ? pwdata[CFG_W-1:0] : cpus_ff;

   always_comb begin
      etok[0].active = accept;
      etok[0].hit = 1'b0;
      etok[0].key = req_line_number;
      etok[0].cpu = '0;
      c_active[0] = accept;
      c_found[0] = 1'b0;
      c_best[0] = '0;
      c_count[0] = '0;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
      llis_entry_cell #(
         .INDEX(i),
         .IDX_W(FILL_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (etok[i]),
         .tok_out (etok[i+1]),
         .wr      (wr),
         .wr_index(fill_ff)
      );
   end

   for (genvar j = 0; j < MAX_CPUS; j++) begin : g_cpu
      llis_cpu_cell #(
         .INDEX(j),
         .CPU_W(CPU_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cpus_in_use(cpus_ff),
         .in_active  (c_active[j]),
         .in_found   (c_found[j]),
         .in_best    (c_best[j]),
         .in_count   (c_count[j]),
         .out_active (c_active[j+1]),
         .out_found  (c_found[j+1]),
         .out_best   (c_best[j+1]),
         .out_count  (c_count[j+1]),
         .inc_en     (inc_en),
         .inc_index  (best_ff)
      );
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      line_in = accept ? req_line_number : line_ff;
      tbl_done_in = tbl_done_ff;
      hit_in = hit_ff;
      hit_cpu_in = hit_cpu_ff;
      cpu_done_in = cpu_done_ff;
      best_in = best_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_cpu_in = '0;
      rsp_vec_in = '0;
      rsp_new_in = 1'b0;
      wr.en = 1'b0;
      wr.line = line_ff;
      wr.cpu = CPU_OUT_W'(best_ff);
      inc_en = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tbl_done_in = 1'b0;
               cpu_done_in = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (etok[TABLE_ENTRIES].active) begin
               tbl_done_in = 1'b1;
               hit_in = etok[TABLE_ENTRIES].hit;
               hit_cpu_in = etok[TABLE_ENTRIES].cpu;
            end
            if (c_active[MAX_CPUS]) begin
               cpu_done_in = 1'b1;
               best_in = c_best[MAX_CPUS];
            end
            if (tbl_done_in && cpu_done_in) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
            if (hit_ff) begin
               rsp_cpu_in = hit_cpu_ff;
               rsp_vec_in = line_ff;
            end else if (cpus_ff == '0) begin
               rsp_status_in = STATUS_NO_CPU;
            end else if (fill_ff == FILL_W'(TABLE_ENTRIES)) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               wr.en = 1'b1;
               inc_en = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
               rsp_cpu_in = CPU_OUT_W'(best_ff);
               rsp_vec_in = line_ff;
               rsp_new_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cpus_ff <= CFG_W'(1);
         fill_ff <= '0;
         tbl_done_ff <= 1'b0;
         cpu_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cpus_ff <= cpus_in;
         fill_ff <= fill_in;
         tbl_done_ff <= tbl_done_in;
         cpu_done_ff <= cpu_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      line_ff <= line_in;
      hit_ff <= hit_in;
      hit_cpu_ff <= hit_cpu_in;
      best_ff <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cpu_ff <= rsp_cpu_in;
      rsp_vec_ff <= rsp_vec_in;
      rsp_new_ff <= rsp_new_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_target_cpu = rsp_cpu_ff;
   assign rsp_vector_number = rsp_vec_ff;
   assign rsp_newly_assigned = rsp_new_ff;

`ifndef ASSERT_OFF
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_new_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_newly_assigned) |-> (rsp_status == STATUS_OK))
      else $error("new assignment reported with an error status");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         ((rsp_target_cpu == '0) && (rsp_vector_number == '0)))
      else $error("error result carries nonzero fields");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TABLE_ENTRIES))
      else $error("table fill count exceeded the table size");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_least_loaded_interrupt_steering.sv =====
`timescale 1ns / 1ps

module tb_least_loaded_interrupt_steering;
   import llis_pkg::*;

   localparam int TABLE_SIZE = 64;
   localparam int NUM_CPUS = 8;
   localparam logic [2:0] CSR_CPUS_IN_USE = 3'd0;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASES = 14;
   localparam int PHASE_ITEMS = 116;

   typedef struct {
      status_type   status;
      logic [2:0]   cpu;
      logic [15:0]  vector;
      logic         fresh;
   } steer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [15:0] req_line_number = '0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic busy;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [2:0] rsp_target_cpu;
   logic [15:0] rsp_vector_number;
   logic rsp_newly_assigned;
   logic [31:0] prdata;
   logic pready;

   least_loaded_interrupt_steering u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_line_number(req_line_number),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_target_cpu(rsp_target_cpu),
      .rsp_vector_number(rsp_vector_number),
      .rsp_newly_assigned(rsp_newly_assigned),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   logic [15:0] line_table [TABLE_SIZE];
   logic [2:0] line_cpu [TABLE_SIZE];
   logic [6:0] cpu_load [NUM_CPUS] = '{default: '0};
   int table_fill = 0;
   logic [3:0] cpus_setting = 4'd1;

   steer_result_type expected_steers [$];
   logic [15:0] line_backlog [$];
   logic [15:0] lines_seen [$];

   logic req_taken = 1'b0;
   logic sender_hold = 1'b0;
   logic idling_on = 1'b1;
   int gap_left = 0;
   int stall_cycles = 0;
   int failures = 0;
   int accepted = 0;
   int fresh_seen = 0;
   int hits_seen = 0;
   int nocpu_seen = 0;
   int full_seen = 0;
   int settings_tried = 1;
   int phase_cfg [PHASES] = '{1, 8, 0, 15, 2, 5, 7, 3, 4, 6, 9, 12, 8, 1};

   function automatic steer_result_type steer_line(input logic [15:0] line);
      steer_result_type r;
      logic found;
      int ncpu;
      int best;
      r.status = STATUS_OK;
      r.cpu = '0;
      r.vector = '0;
      r.fresh = 1'b0;
      found = 1'b0;
      for (int i = 0; i < table_fill; i++) begin
         if (!found && line_table[i] == line) begin
            found = 1'b1;
            r.cpu = line_cpu[i];
            r.vector = line;
         end
      end
      if (!found) begin
         ncpu = (cpus_setting > NUM_CPUS) ? NUM_CPUS : cpus_setting;
         if (ncpu == 0) begin
            r.status = STATUS_NO_CPU;
         end else if (table_fill >= TABLE_SIZE) begin
            r.status = STATUS_FULL;
         end else begin
            best = 0;
            for (int i = 1; i < ncpu; i++) begin
               if (cpu_load[i] < cpu_load[best]) best = i;
            end
            line_table[table_fill] = line;
            line_cpu[table_fill] = best[2:0];
            table_fill++;
            if (cpu_load[best] < LOAD_MAX) cpu_load[best]++;
            r.cpu = best[2:0];
            r.vector = line;
            r.fresh = 1'b1;
         end
      end
      return r;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_line_number <= '0;
      end else if (!(start && !req_taken)) begin
         if (gap_left > 0) begin
            if (!busy) gap_left--;
            start <= 1'b0;
         end else if (line_backlog.size() > 0 && !sender_hold) begin
            start <= 1'b1;
            req_line_number <= line_backlog.pop_front();
            if (idling_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 16);
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      steer_result_type want;
      logic progress;
      req_taken <= !reset && start && !busy;
      if (!reset) begin
         progress = 1'b0;
         if (psel && penable && pwrite && pready) begin
            cpus_setting = pwdata[3:0];
            progress = 1'b1;
         end
         if (rsp_valid) begin
            progress = 1'b1;
            if (expected_steers.size() == 0) begin
               $error("result with no request outstanding: status %0d cpu %0d vector %0h",
                      rsp_status, rsp_target_cpu, rsp_vector_number);
               failures++;
            end else begin
               want = expected_steers.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_target_cpu !== want.cpu) begin
                  $error("target_cpu: expected %0d, got %0d", want.cpu, rsp_target_cpu);
                  failures++;
               end
               if (rsp_vector_number !== want.vector) begin
                  $error("vector_number: expected %0h, got %0h", want.vector,
                         rsp_vector_number);
                  failures++;
               end
               if (rsp_newly_assigned !== want.fresh) begin
                  $error("newly_assigned: expected %0d, got %0d", want.fresh,
                         rsp_newly_assigned);
                  failures++;
               end
               if (want.status == STATUS_NO_CPU) nocpu_seen++;
               else if (want.status == STATUS_FULL) full_seen++;
               else if (want.fresh) fresh_seen++;
               else hits_seen++;
            end
         end
         if (start && !busy) begin
            expected_steers.push_back(steer_line(req_line_number));
            accepted++;
            progress = 1'b1;
         end
         if (progress) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_least_loaded_interrupt_steering: errors");
            $finish;
         end
      end
   end

   task automatic queue_line(input logic [15:0] line);
      line_backlog.push_back(line);
      lines_seen.push_back(line);
   endtask

   task automatic drain();
      while (line_backlog.size() != 0 || start) @(posedge clock);
      while (expected_steers.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] value);
      drain();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_CPUS_IN_USE;
      pwdata <= {28'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_tried++;
   endtask

   initial begin
      int pick;
      logic [15:0] line;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Two lines land on the only CPU, then are found again.
      queue_line(16'h0000);
      queue_line(16'hFFFF);
      queue_line(16'h0000);
      queue_line(16'hFFFF);
      // With no CPUs a new line is refused, but assigned lines still resolve.
      csr_write(4'd0);
      queue_line(16'h1234);
      queue_line(16'h0000);
      queue_line(16'hFFFF);
      csr_write(4'd8);
      queue_line(16'hA5A5);
      queue_line(16'h5A5A);
      queue_line(16'h0001);
      queue_line(16'h8000);
      queue_line(16'h7FFF);
      queue_line(16'hFFFE);
      queue_line(16'h0100);
      queue_line(16'h00FF);
      queue_line(16'h5A5A);
      // A setting above the CPU count behaves as the full count.
      csr_write(4'd15);
      queue_line(16'h3C3C);
      queue_line(16'hC3C3);
      queue_line(16'h1111);
      csr_write(4'd3);
      queue_line(16'h2222);
      queue_line(16'h4444);

      for (int p = 0; p < PHASES; p++) begin
         csr_write(phase_cfg[p][3:0]);
         idling_on = (p < PHASES - 2) && (p % 4 != 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 4 && k == PHASE_ITEMS / 2) begin
               sender_hold = 1'b1;
               while (expected_steers.size() != 0 || busy || start) @(posedge clock);
               sender_hold = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               line = $urandom_range(0, 16'hFFFF);
            end else begin
               line = lines_seen[$urandom_range(0, lines_seen.size() - 1)];
               if (pick >= 95) line[$urandom_range(0, 15)] ^= 1'b1;
            end
            queue_line(line);
         end
      end

      drain();
      repeat (80) @(posedge clock);
      $display("Steered %0d requests over %0d settings of cpus_in_use; table holds %0d lines.",
               accepted, settings_tried, table_fill);
      $display("New assignments %0d, repeat lookups %0d, no-CPU refusals %0d, full refusals %0d.",
               fresh_seen, hits_seen, nocpu_seen, full_seen);
      if (failures == 0) begin
         $display("tb_least_loaded_interrupt_steering: clean");
      end else begin
         $display("tb_least_loaded_interrupt_steering: errors");
      end
      $finish;
   end

endmodule

// ===== least_loaded_interrupt_steering.f =====
rtl/llis_pkg.sv
rtl/llis_entry_cell.sv
rtl/llis_cpu_cell.sv
rtl/least_loaded_interrupt_steering.sv
tb/tb_least_loaded_interrupt_steering.sv
